[rtl/nsc_pkg.sv]
// Shared constants, types and helper functions for the NMEA sentence checker.
package nsc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [2:0] TAG_LEN   = 3'd6;

    localparam logic KIND_GGA = 1'b0;
    localparam logic KIND_VTG = 1'b1;

    typedef struct packed {
        logic       kind;
        logic       ok;
        logic [7:0] xsum;
    } result_t;

    function automatic logic [7:0] gga_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h47; // G
            3'd1:    c = 8'h50; // P
            3'd2:    c = 8'h47; // G
            3'd3:    c = 8'h47; // G
            3'd4:    c = 8'h41; // A
            3'd5:    c = 8'h2C; // ,
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] vtg_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h47; // G
            3'd1:    c = 8'h50; // P
            3'd2:    c = 8'h56; // V
            3'd3:    c = 8'h54; // T
            3'd4:    c = 8'h47; // G
            3'd5:    c = 8'h2C; // ,
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // uppercase ASCII hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = 8'h30 + {4'd0, nib};
        else
            c = 8'h41 + {4'd0, nib} - 8'd10;
        return c;
    endfunction

endpackage

[rtl/nsc_frame.sv]
// Sentence framing, tag match and checksum tracking, one word per enabled cycle.
module nsc_frame
    import nsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] word,
    output logic       emit,
    output result_t    result
);

    logic       in_frame_reg,  in_frame_next;
    logic [2:0] tag_pos_reg,   tag_pos_next;
    logic       gga_reg,       gga_next;
    logic       vtg_reg,       vtg_next;
    logic [7:0] xor_reg,       xor_next;
    logic       star_reg,      star_next;
    logic [1:0] digits_reg,    digits_next;
    logic       dmatch_reg,    dmatch_next;
    logic [7:0] want;

    assign want = (digits_reg == 2'd0) ? hex_char(xor_reg[7:4]) : hex_char(xor_reg[3:0]);

    assign emit = (word == CH_LF) && in_frame_reg && (tag_pos_reg >= TAG_LEN)
                  && (gga_reg || vtg_reg);
    assign result.kind = gga_reg ? KIND_GGA : KIND_VTG;
    assign result.ok   = star_reg && (digits_reg == 2'd2) && dmatch_reg;
    assign result.xsum = xor_reg;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        tag_pos_next  = tag_pos_reg;
        gga_next      = gga_reg;
        vtg_next      = vtg_reg;
        xor_next      = xor_reg;
        star_next     = star_reg;
        digits_next   = digits_reg;
        dmatch_next   = dmatch_reg;
        if (word == CH_DOLLAR)
        begin
            in_frame_next = 1'b1;
            tag_pos_next  = 3'd0;
            gga_next      = 1'b1;
            vtg_next      = 1'b1;
            xor_next      = 8'd0;
            star_next     = 1'b0;
            digits_next   = 2'd0;
            dmatch_next   = 1'b1;
        end
        else if (word == CH_LF)
        begin
            in_frame_next = 1'b0;
        end
        else if (in_frame_reg)
        begin
            if (tag_pos_reg < TAG_LEN)
            begin
                if (word != gga_char(tag_pos_reg))
                    gga_next = 1'b0;
                if (word != vtg_char(tag_pos_reg))
                    vtg_next = 1'b0;
                tag_pos_next = tag_pos_reg + 3'd1;
            end
            if (!star_reg)
            begin
                if (word == CH_STAR)
                    star_next = 1'b1;
                else
                    xor_next = xor_reg ^ word;
            end
            else if (digits_reg < 2'd2)
            begin
                if (word != want)
                    dmatch_next = 1'b0;
                digits_next = digits_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            tag_pos_reg  <= 3'd0;
            gga_reg      <= 1'b0;
            vtg_reg      <= 1'b0;
            xor_reg      <= 8'd0;
            star_reg     <= 1'b0;
            digits_reg   <= 2'd0;
            dmatch_reg   <= 1'b0;
        end
        else if (en)
        begin
            in_frame_reg <= in_frame_next;
            tag_pos_reg  <= tag_pos_next;
            gga_reg      <= gga_next;
            vtg_reg      <= vtg_next;
            xor_reg      <= xor_next;
            star_reg     <= star_next;
            digits_reg   <= digits_next;
            dmatch_reg   <= dmatch_next;
        end
    end

endmodule

[rtl/nsc_out_stage.sv]
// Result register with valid/ready handshake toward the consumer.
module nsc_out_stage
    import nsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  result_t    din,
    output logic       can_take,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       sentence_kind,
    output logic       checksum_ok,
    output logic [7:0] computed_checksum
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_take   = !valid_reg || out_ready;
    assign valid_next = (load && can_take) ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && can_take)
            data_reg <= din;
    end

    assign out_valid         = valid_reg;
    assign sentence_kind     = data_reg.kind;
    assign checksum_ok       = data_reg.ok;
    assign computed_checksum = data_reg.xsum;

endmodule

[rtl/nmea_sentence_checker.sv]
// NMEA sentence checker top level: input word register, checker, result register.
// The line feed word ending a GGA or VTG sentence waits in the input register
// until the result register takes its result. Throughput: one word per cycle; the input
// stage stalls only while a result waits and the result register is still full.
// Reset (rst_n, async, active low) clears both valid flags and all sentence state.
module nmea_sentence_checker
    import nsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       sentence_kind,
    output logic       checksum_ok,
    output logic [7:0] computed_checksum
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_word_reg;
    logic       emit;
    logic       can_take;
    logic       advance;
    result_t    result;

    assign advance  = s1_valid_reg && (!emit || can_take);
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_word_reg <= rx_byte;
    end

    nsc_frame u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .word   (s1_word_reg),
        .emit   (emit),
        .result (result)
    );

    nsc_out_stage u_out (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (advance && emit),
        .din               (result),
        .can_take          (can_take),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .sentence_kind     (sentence_kind),
        .checksum_ok       (checksum_ok),
        .computed_checksum (computed_checksum)
    );

endmodule
